/* rtl/lu8dec_pkg.sv */
// Shared types, constants and lead-byte classification for the lenient UTF-8 decoder.
// No dependencies.
package lu8dec_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef enum logic [2:0] {
    FORM_BAD = 3'd0,
    FORM_1   = 3'd1,
    FORM_2   = 3'd2,
    FORM_3   = 3'd3,
    FORM_4   = 3'd4
  } form_t;

  typedef struct packed {
    logic            last;
    logic [CP_W-1:0] cp;
  } res_t;

  function automatic form_t form_length(input logic [BYTE_W-1:0] c);
    form_t f;
    priority if (c[7] == 1'b0)         f = FORM_1;
    else if (c[7:5] == 3'b110)         f = FORM_2;
    else if (c[7:4] == 4'b1110)        f = FORM_3;
    else if (c[7:3] == 5'b11110)       f = FORM_4;
    else                               f = FORM_BAD;
    return f;
  endfunction

endpackage

/* rtl/lenient_utf8_stream_decoder.sv */
// Lenient UTF-8 byte-stream decoder: one byte in, zero to two code points out.
// A result is registered in the result queue and shown once the results ahead of it are taken.
// Throughput: one byte per cycle while at most one result is queued; a text
// cut short inside a 4-byte form may give two results, from a three-entry queue.
// Reset (rst_n low, synchronous) empties the queue and closes any open sequence.
// Depends on lu8dec_pkg.
module lenient_utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_text
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic        out_tlast,  // run_last
  output logic        out_tvalid,
  input  logic        out_tready
);
  import lu8dec_pkg::*;

  logic [BYTE_W-1:0] held_r [3];
  logic [1:0]        hc_r, hc_nxt;
  form_t             seq_r, seq_nxt;

  res_t              q_r [3];
  res_t              q_nxt [3];
  res_t              q_s [3];
  logic [1:0]        cnt_r, cnt_nxt, base;

  logic              acc, pop, wr_held, eot;
  logic [1:0]        wr_idx, n_res;
  logic [BYTE_W-1:0] b;
  logic [CP_W-1:0]   cp0, cp1;
  form_t             fl, fl_h1;
  res_t              res0, res1;

  assign b         = in_tdata;
  assign eot       = in_tlast;
  assign in_tready = (cnt_r <= 2'd1);
  assign acc       = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign pop       = out_tvalid && out_tready;
  assign out_tdata = {{(OUT_TDATA_W-CP_W){1'b0}}, q_r[0].cp};
  assign out_tlast = q_r[0].last;

  // decode
  always_comb begin
    fl      = form_length(b);
    fl_h1   = form_length(held_r[1]);
    n_res   = 2'd0;
    cp0     = '0;
    cp1     = '0;
    hc_nxt  = hc_r;
    seq_nxt = seq_r;
    wr_held = 1'b0;
    wr_idx  = hc_r;
    if (seq_r == FORM_BAD || hc_r == 2'd0) begin
      hc_nxt  = 2'd0;
      seq_nxt = FORM_BAD;
      wr_idx  = 2'd0;
      if (fl == FORM_1) begin
        n_res = 2'd1;
        cp0   = {{(CP_W-BYTE_W){1'b0}}, b};
      end else if (fl != FORM_BAD && !eot) begin
        wr_held = 1'b1;
        hc_nxt  = 2'd1;
        seq_nxt = fl;
      end
    end else if ({1'b0, hc_r} + 3'd1 >= seq_r) begin
      n_res = 2'd1;
      unique case (seq_r)
        FORM_2:  cp0 = {10'd0, held_r[0][4:0], b[5:0]};
        FORM_3:  cp0 = {5'd0, held_r[0][3:0], held_r[1][5:0], b[5:0]};
        FORM_4:  cp0 = {held_r[0][2:0], held_r[1][5:0], held_r[2][5:0], b[5:0]};
        default: cp0 = '0;
      endcase
      hc_nxt  = 2'd0;
      seq_nxt = FORM_BAD;
    end else if (eot) begin
      // truncated: lead dropped, rest decoded again
      if (hc_r == 2'd1) begin
        if (fl == FORM_1) begin
          n_res = 2'd1;
          cp0   = {{(CP_W-BYTE_W){1'b0}}, b};
        end
      end else begin
        if (fl_h1 == FORM_1) begin
          cp0 = {{(CP_W-BYTE_W){1'b0}}, held_r[1]};
          if (fl == FORM_1) begin
            n_res = 2'd2;
            cp1   = {{(CP_W-BYTE_W){1'b0}}, b};
          end else begin
            n_res = 2'd1;
          end
        end else if (fl_h1 == FORM_2) begin
          n_res = 2'd1;
          cp0   = {10'd0, held_r[1][4:0], b[5:0]};
        end else if (fl == FORM_1) begin
          n_res = 2'd1;
          cp0   = {{(CP_W-BYTE_W){1'b0}}, b};
        end
      end
      hc_nxt  = 2'd0;
      seq_nxt = FORM_BAD;
    end else begin
      wr_held = 1'b1;
      hc_nxt  = hc_r + 2'd1;
    end
    if (eot) begin
      hc_nxt  = 2'd0;
      seq_nxt = FORM_BAD;
    end
  end

  assign res0 = '{last: (n_res == 2'd1), cp: cp0};
  assign res1 = '{last: 1'b1, cp: cp1};

  // result queue
  always_comb begin
    base   = cnt_r - {1'b0, pop};
    q_s[0] = pop ? q_r[1] : q_r[0];
    q_s[1] = pop ? q_r[2] : q_r[1];
    q_s[2] = q_r[2];
    for (int i = 0; i < 3; i++) begin
      q_nxt[i] = q_s[i];
      if (acc && n_res != 2'd0 && base == 2'(i)) q_nxt[i] = res0;
      if (acc && n_res == 2'd2 && base + 2'd1 == 2'(i)) q_nxt[i] = res1;
    end
    cnt_nxt = base + (acc ? n_res : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r  <= 2'd0;
      seq_r <= FORM_BAD;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) begin
        hc_r  <= hc_nxt;
        seq_r <= seq_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) q_r[i] <= q_nxt[i];
    if (acc && wr_held) held_r[wr_idx] <= b;
  end

endmodule

/* rtl/lu8dec_checker.sv */
// Port-level checks for lenient_utf8_stream_decoder, attached by bind.
// Depends on lu8dec_pkg.
module lu8dec_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tvalid,
  input logic        out_tready
);
  import lu8dec_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:CP_W] == '0)
    else $error("tdata padding not zero");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("queue not empty after reset");

  // input only backs up behind pending results
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

endmodule

bind lenient_utf8_stream_decoder lu8dec_checker u_lu8dec_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
